// ----- rtl/core/ush_pkg.sv -----
// Shared constants and types for the universal string hash block.
// No dependencies; compiled first.

package ush_pkg;

	localparam int KEY_W  = 8;              // key byte width
	localparam int IDX_W  = 16;             // bucket index / running state width
	localparam int SIZE_W = 17;             // table size register width
	localparam int PROD_W = 2 * IDX_W;      // product width fed to the remainder units

	localparam logic [IDX_W-1:0]  SEED_MULT  = 16'd31415;
	localparam logic [IDX_W-1:0]  MULT_STEP  = 16'd27183;
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 17'd2;
	localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd256;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

endpackage

// ----- rtl/core/ush_if.sv -----
// Handshake channel interfaces: key bytes in, bucket indexes out, table size writes.
// Depends on ush_pkg.

interface ush_key_if;
	import ush_pkg::*;
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_byte;
	modport source (output valid, output key_byte, input ready);
	modport sink   (input valid, input key_byte, output ready);
endinterface

interface ush_bucket_if;
	import ush_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] bucket_index;
	modport source (output valid, output bucket_index, input ready);
	modport sink   (input valid, input bucket_index, output ready);
endinterface

interface ush_cfg_if;
	import ush_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] bucket_count;
	modport source (output valid, output bucket_count, input ready);
	modport sink   (input valid, input bucket_count, output ready);
endinterface

// ----- rtl/core/ush_modred.sv -----
// Bit-serial remainder unit: shifts the dividend in MSB first, one bit per cycle,
// keeping a partial remainder below the divisor. Depends on ush_pkg for defaults.

module ush_modred #(
	parameter int DVD_W = ush_pkg::PROD_W,
	parameter int DIV_W = ush_pkg::SIZE_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-2:0] remainder
);
	localparam int              CNT_W = $clog2(DVD_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-2:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W-1:0] trial;
	logic [DIV_W-1:0] diff;
	logic [DIV_W-2:0] rem_nxt;

	// partial remainder < divisor, so one conditional subtract per bit suffices
	assign trial   = {rem_q, dvd_q[DVD_W-1]};
	assign diff    = trial - div_q;
	assign rem_nxt = (trial >= div_q) ? diff[DIV_W-2:0] : trial[DIV_W-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/core/universal_string_hash_top.sv -----
// Universal string hash, one key byte per request.
// Nonzero byte: accepted, then 32 bit-serial remainder steps and one write-back;
// no byte is taken until the write-back. The 32-bit products set the step count.
// Terminating zero byte: bucket index valid in the cycle after accept.
// Reset: table size 256, hash 0, multiplier 31415, no result pending.
// Depends on ush_pkg, ush_if, ush_modred.

module universal_string_hash_top (
	input  logic         clk,
	input  logic         arst_n,
	ush_key_if.sink      key,
	ush_bucket_if.source bucket,
	ush_cfg_if.sink      cfg
);
	import ush_pkg::*;

	state_t            state_q;
	logic [SIZE_W-1:0] bucket_count_q;
	logic [IDX_W-1:0]  hash_q;
	logic [IDX_W-1:0]  mult_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_vld_q;

	logic              is_end;
	logic              accept;
	logic              start;
	logic [PROD_W-1:0] mh;
	logic [PROD_W-1:0] prod_h;
	logic [PROD_W-1:0] prod_m;
	logic [SIZE_W-1:0] size_m1;
	logic              done_h;
	logic              done_m;
	logic [IDX_W-1:0]  rem_h;
	logic [IDX_W-1:0]  rem_m;

	assign is_end = (key.key_byte == '0);
	// a nonzero byte needs no output slot, so it may enter while a result waits
	assign key.ready = (state_q == ST_IDLE) &&
	                   (!is_end || !out_vld_q || bucket.ready);
	assign accept = key.valid && key.ready;
	assign start  = accept && !is_end;

	assign mh      = mult_q * hash_q;
	assign prod_h  = mh + PROD_W'(key.key_byte);
	assign prod_m  = mult_q * MULT_STEP;
	assign size_m1 = bucket_count_q - 1'b1;

	ush_modred #(.DVD_W(PROD_W), .DIV_W(SIZE_W)) u_red_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dividend  (prod_h),
		.divisor   (bucket_count_q),
		.done      (done_h),
		.remainder (rem_h)
	);

	ush_modred #(.DVD_W(PROD_W), .DIV_W(SIZE_W)) u_red_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dividend  (prod_m),
		.divisor   (size_m1),
		.done      (done_m),
		.remainder (rem_m)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hash_q  <= '0;
			mult_q  <= SEED_MULT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
					end else if (accept) begin
						hash_q <= '0;
						mult_q <= SEED_MULT;
					end
				end
				ST_RUN: begin
					// both units start together and finish in the same cycle
					if (done_h && done_m) begin
						hash_q  <= rem_h;
						mult_q  <= rem_m;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept && is_end) begin
			out_vld_q <= 1'b1;
		end else if (bucket.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_end) begin
			out_idx_q <= hash_q;
		end
	end

	assign bucket.valid        = out_vld_q;
	assign bucket.bucket_index = out_idx_q;

	// table size saturates to 2..65536
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			if (cfg.bucket_count < SIZE_MIN) begin
				bucket_count_q <= SIZE_MIN;
			end else if (cfg.bucket_count > SIZE_MAX) begin
				bucket_count_q <= SIZE_MAX;
			end else begin
				bucket_count_q <= cfg.bucket_count;
			end
		end
	end

endmodule
